>>> rtl/pta_pkg.sv
// ----------------------------------------------------------------------------
// pta_pkg
// Shared types and constants for the process-id table.
// ----------------------------------------------------------------------------
package pta_pkg;

  localparam int PID_W  = 6;
  localparam int STAT_W = 10;
  localparam int CODE_W = 8;
  // Wide enough for any supported table size (up to 1024 slots).
  localparam int LIM_W  = 11;
  localparam int IDX_W  = 10;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_EXIT   = 2'd1,
    FN_REMOVE = 2'd2,
    FN_GET    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic {
    SW_ADD  = 1'b0,
    SW_EXIT = 1'b1
  } sweep_op_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_SWEEP = 2'd2,
    S_RESP  = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [PID_W-1:0] pid;
    logic             has_parent;
    logic [PID_W-1:0] parent_pid;
    logic [CODE_W-1:0] exit_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PID_W-1:0]  result_pid;
    logic              result_has_parent;
    logic [PID_W-1:0]  result_parent;
    logic              is_exited;
    logic [STAT_W-1:0] exit_status;
    logic              wake_parent;
  } out_item_t;

  // Token that walks the chain, one cell per cycle.
  typedef struct packed {
    logic              valid;
    sweep_op_t         op;
    logic [PID_W-1:0]  pid;
    logic              has_parent;
    logic [PID_W-1:0]  parent_pid;
    logic [LIM_W-1:0]  limit;
    logic              found;
    logic [IDX_W-1:0]  got;
    logic [LIM_W-1:0]  dec;
  } token_t;

  // Direct access to the cell addressed by pid.
  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic              set_exit;
    logic              free;
    logic [STAT_W-1:0] status;
  } dir_t;

  typedef struct packed {
    logic              used;
    logic              has_parent;
    logic [PID_W-1:0]  parent;
    logic              exited;
    logic [STAT_W-1:0] status;
  } slot_t;

endpackage

>>> rtl/pid_table_allocator.sv
// ----------------------------------------------------------------------------
// pid_table_allocator
// Process-id table built as a chain of slot cells with a walking token.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                          Carries
//  input     in_valid / in_ready / in_data  one operation (add/exit/remove/get)
//  result    out_valid / out_ready / out_data  one result per operation
//
//  Get, remove and rejected operations go from S_EXEC straight to S_RESP.
//  Add and a successful exit pass through S_SWEEP, where the token walks the
//  whole cell chain one slot per cycle, so the chain length sets their latency.
//  One transaction is in work at a time; in_ready is high only when idle.
//  Reset clears the slots' used flags and live count; the limit loads INIT.
//  A stalled result holds in the output register until taken.
//
module pid_table_allocator #(
  parameter int MAX_IDS     = 64,
  parameter int FIRST_ID    = 2,
  parameter int START_LIMIT = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pta_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pta_pkg::out_item_t  out_data
);
  import pta_pkg::*;

  localparam int LW   = $clog2(MAX_IDS + 1);
  localparam int IW   = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int INIT = (START_LIMIT > MAX_IDS) ? MAX_IDS : START_LIMIT;

  state_t    state_r, state_nxt;
  in_item_t  req_r, req_nxt;
  out_item_t res_r, res_nxt;
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic [LW-1:0] live_r, live_nxt;
  logic [LW-1:0] limit_r, limit_nxt;
  token_t    launch_r, launch_nxt;
  dir_t      dir;

  token_t    chain [MAX_IDS+1];
  slot_t     slots [MAX_IDS];

  // Slot addressed by the request pid
  slot_t     cur;
  logic      pid_ok;
  logic [LW:0] dbl;
  token_t    last_tok;

  assign chain[0] = launch_r;
  assign last_tok = chain[MAX_IDS];

  for (genvar g = 0; g < MAX_IDS; g++) begin : g_cell
    pta_cell #(.IDX(g), .FIRST_ID(FIRST_ID)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (chain[g]),
      .dir     (dir),
      .tok_out (chain[g+1]),
      .slot    (slots[g])
    );
  end

  always_comb begin
    if ({{(LIM_W-PID_W){1'b0}}, req_r.pid} < LIM_W'(MAX_IDS)) begin
      cur = slots[IW'(req_r.pid)];
    end else begin
      cur = '0;
    end
  end

  // pid in range [FIRST_ID, active limit) and in use
  assign pid_ok = ({{(LIM_W-PID_W){1'b0}}, req_r.pid} >= LIM_W'(FIRST_ID))
                  && ({{(LIM_W-PID_W){1'b0}}, req_r.pid} < LIM_W'(limit_r))
                  && cur.used;

  assign dbl = {limit_r, 1'b0};

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    live_nxt      = live_r;
    limit_nxt     = limit_r;
    launch_nxt    = launch_r;
    launch_nxt.valid = 1'b0;
    dir           = '{pid: req_r.pid, set_exit: 1'b0, free: 1'b0,
                      status: {req_r.exit_code, 2'b00}};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt            = '0;
        res_nxt.result_pid = req_r.pid;
        launch_nxt = '{valid: 1'b1, op: SW_ADD, pid: req_r.pid,
                       has_parent: req_r.has_parent, parent_pid: req_r.parent_pid,
                       limit: LIM_W'(limit_r), found: 1'b0, got: '0, dec: '0};
        unique case (func_t'(req_r.func))
          FN_ADD: begin
            res_nxt.result_pid = '0;
            if (live_r == limit_r - LW'(1)) begin
              if (limit_r < LW'(MAX_IDS)) begin
                // grow the limit before searching
                limit_nxt = (dbl > (LW+1)'(MAX_IDS)) ? LW'(MAX_IDS) : dbl[LW-1:0];
                launch_nxt.limit = LIM_W'(limit_nxt);
                state_nxt = S_SWEEP;
              end else begin
                launch_nxt.valid = 1'b0;
                res_nxt.status   = ST_FULL;
                state_nxt        = S_RESP;
              end
            end else begin
              state_nxt = S_SWEEP;
            end
          end
          FN_EXIT: begin
            if (!pid_ok || cur.exited) begin
              launch_nxt.valid = 1'b0;
              res_nxt.status   = ST_INVALID;
              state_nxt        = S_RESP;
            end else begin
              dir.set_exit  = 1'b1;
              launch_nxt.op = SW_EXIT;
              state_nxt     = S_SWEEP;
            end
          end
          FN_REMOVE: begin
            launch_nxt.valid = 1'b0;
            state_nxt        = S_RESP;
            if (!pid_ok) begin
              res_nxt.status = ST_INVALID;
            end else begin
              dir.free = 1'b1;
              live_nxt = live_r - LW'(1);
            end
          end
          FN_GET: begin
            launch_nxt.valid = 1'b0;
            state_nxt        = S_RESP;
            if (!pid_ok) begin
              res_nxt.status = ST_INVALID;
            end else begin
              res_nxt.result_has_parent = cur.has_parent;
              res_nxt.result_parent     = cur.parent;
              res_nxt.is_exited         = cur.exited;
              res_nxt.exit_status       = cur.status;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_SWEEP: begin
        if (last_tok.valid) begin
          state_nxt = S_RESP;
          if (last_tok.op == SW_ADD) begin
            if (last_tok.found) begin
              live_nxt           = live_r + LW'(1);
              res_nxt.result_pid = last_tok.got[PID_W-1:0];
            end else begin
              res_nxt.status = ST_FULL;
            end
          end else begin
            // children are settled; now the exiting entry itself
            if (cur.used && !cur.has_parent) begin
              dir.free = 1'b1;
              live_nxt = live_r - last_tok.dec[LW-1:0] - LW'(1);
            end else begin
              live_nxt            = live_r - last_tok.dec[LW-1:0];
              res_nxt.wake_parent = cur.used;
            end
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      live_r         <= '0;
      limit_r        <= LW'(INIT);
      launch_r.valid <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      live_r         <= live_nxt;
      limit_r        <= limit_nxt;
      launch_r.valid <= launch_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    req_r               <= req_nxt;
    res_r               <= res_nxt;
    out_r               <= out_nxt;
    launch_r.op         <= launch_nxt.op;
    launch_r.pid        <= launch_nxt.pid;
    launch_r.has_parent <= launch_nxt.has_parent;
    launch_r.parent_pid <= launch_nxt.parent_pid;
    launch_r.limit      <= launch_nxt.limit;
    launch_r.found      <= launch_nxt.found;
    launch_r.got        <= launch_nxt.got;
    launch_r.dec        <= launch_nxt.dec;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // No token may be on the chain while the block is idle.
  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!launch_r.valid && !last_tok.valid))
    else $error("token on chain while idle");

  // Live entries never exceed the active limit.
  a_live_le_limit: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= limit_r)
    else $error("live count above limit");

  // The active limit only grows.
  a_limit_grows: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (limit_r >= $past(limit_r)))
    else $error("active limit shrank");

endmodule

>>> rtl/pta_cell.sv
// ----------------------------------------------------------------------------
// pta_cell
// One table slot; forwards the sweep token to the next cell every cycle.
// ----------------------------------------------------------------------------
module pta_cell #(
  parameter int IDX      = 0,
  parameter int FIRST_ID = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pta_pkg::token_t tok_in,
  input  pta_pkg::dir_t   dir,
  output pta_pkg::token_t tok_out,
  output pta_pkg::slot_t  slot
);
  import pta_pkg::*;

  logic              used_r, used_nxt;
  logic              hp_r, hp_nxt;
  logic [PID_W-1:0]  parent_r, parent_nxt;
  logic              exited_r, exited_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  token_t            tok_r, tok_nxt;
  logic              in_rng, sel, take, match;

  assign in_rng = (IDX >= FIRST_ID) && (LIM_W'(IDX) < tok_in.limit);
  assign sel    = ({{(LIM_W-PID_W){1'b0}}, dir.pid} == LIM_W'(IDX));
  assign take   = tok_in.valid && (tok_in.op == SW_ADD) && !tok_in.found
                  && in_rng && !used_r;
  assign match  = tok_in.valid && (tok_in.op == SW_EXIT) && in_rng && used_r
                  && hp_r && (parent_r == tok_in.pid);

  always_comb begin
    used_nxt   = used_r;
    hp_nxt     = hp_r;
    parent_nxt = parent_r;
    exited_nxt = exited_r;
    status_nxt = status_r;
    tok_nxt    = tok_in;
    if (sel && dir.set_exit) begin
      exited_nxt = 1'b1;
      status_nxt = dir.status;
    end
    if (sel && dir.free) begin
      used_nxt = 1'b0;
    end
    if (take) begin
      used_nxt      = 1'b1;
      hp_nxt        = tok_in.has_parent;
      parent_nxt    = tok_in.has_parent ? tok_in.parent_pid : '0;
      exited_nxt    = 1'b0;
      status_nxt    = '0;
      tok_nxt.found = 1'b1;
      tok_nxt.got   = IDX_W'(IDX);
    end
    if (match) begin
      if (!exited_r) begin
        // running child becomes an orphan
        hp_nxt     = 1'b0;
        parent_nxt = '0;
      end else begin
        used_nxt    = 1'b0;
        tok_nxt.dec = tok_in.dec + LIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    hp_r             <= hp_nxt;
    parent_r         <= parent_nxt;
    exited_r         <= exited_nxt;
    status_r         <= status_nxt;
    tok_r.op         <= tok_nxt.op;
    tok_r.pid        <= tok_nxt.pid;
    tok_r.has_parent <= tok_nxt.has_parent;
    tok_r.parent_pid <= tok_nxt.parent_pid;
    tok_r.limit      <= tok_nxt.limit;
    tok_r.found      <= tok_nxt.found;
    tok_r.got        <= tok_nxt.got;
    tok_r.dec        <= tok_nxt.dec;
  end

  assign tok_out = tok_r;
  assign slot    = '{used: used_r, has_parent: hp_r, parent: parent_r,
                     exited: exited_r, status: status_r};

endmodule
